// ===== rtl/wdct_pkg.sv =====
// Shared definitions for the windowed distinct-contact tracker.
// Holds field widths, register indexes, reset values, the sequencer state type
// and the window age test. It depends on nothing else.
package wdct_pkg;

	localparam int TIME_BITS     = 32;
	localparam int WIN_BITS      = 16;
	localparam int QMIN_BITS     = 2;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_QMIN   = 1'b1;

	localparam logic [WIN_BITS-1:0]  WINDOW_RESET = 16'd240;
	localparam logic [QMIN_BITS-1:0] QMIN_RESET   = 2'd2;

	localparam logic MODE_NOTE  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_WRITE,
		ST_FIN
	} state_t;

	// Status from the row scan to the sequencer.
	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

	// True when the age now - last exceeds the window. The sum is one bit wider
	// so that it never wraps; a time that went backwards counts as fresh.
	function automatic logic too_old(input logic [TIME_BITS-1:0] now,
	                                 input logic [TIME_BITS-1:0] last,
	                                 input logic [WIN_BITS-1:0] win);
		logic [TIME_BITS:0] lim;
		lim = {1'b0, last} + (TIME_BITS+1)'(win);
		return ({1'b0, now} > lim);
	endfunction

endpackage

// ===== rtl/wdct_if.sv =====
// Valid/ready channel interfaces for requests and results of the tracker.
// Depends on wdct_pkg for the time field width.
interface wdct_req_if #(
	parameter int KEY_BITS = 48
) ();
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [KEY_BITS-1:0]            station_key;
	logic [KEY_BITS-1:0]            addressee_key;
	logic [wdct_pkg::TIME_BITS-1:0] now_seconds;

	modport source (output valid, mode, station_key, addressee_key, now_seconds,
	                input ready);
	modport sink (input valid, mode, station_key, addressee_key, now_seconds,
	              output ready);
endinterface

interface wdct_rsp_if ();
	logic valid;
	logic ready;
	logic is_queue;
	logic became_queue;

	modport source (output valid, is_queue, became_queue, input ready);
	modport sink (input valid, is_queue, became_queue, output ready);
endinterface

// ===== rtl/wdct_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wdct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/wdct_row_scan.sv =====
// Row scan: reads every row of the row RAM in turn, finds the station's row
// and the oldest row, and keeps the per-row valid bits. Depends on wdct_pkg.
module wdct_row_scan #(
	parameter int ROWS     = 6,
	parameter int KEY_BITS = 48,
	parameter int CW       = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [KEY_BITS-1:0]                  key,
	input  logic                                 wr_mark,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_idx,
	input  logic [KEY_BITS-1:0]                  ram_station,
	input  logic [CW-1:0]                        ram_count,
	input  logic [wdct_pkg::TIME_BITS-1:0]       ram_time,
	output logic                                 rd_en,
	output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
	output wdct_pkg::scan_stat_t                 stat,
	output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] sel_idx,
	output logic [CW-1:0]                        sel_count,
	output logic [wdct_pkg::TIME_BITS-1:0]       sel_time
);

	localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int NW = $clog2(ROWS + 1);
	localparam int TB = wdct_pkg::TIME_BITS;
	localparam logic [IW-1:0] LAST_IDX  = IW'(ROWS - 1);
	localparam logic [NW-1:0] LAST_ISSUE = NW'(ROWS - 1);

	logic              act_q;
	logic [NW-1:0]     issue_q;
	logic              cmp_vld_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic [ROWS-1:0]   valid_q;
	logic              found_q;
	logic              done_q;
	logic [IW-1:0]     fnd_idx_q;
	logic [CW-1:0]     fnd_cnt_q;
	logic [TB-1:0]     fnd_time_q;
	logic [IW-1:0]     old_idx_q;
	logic [TB-1:0]     old_time_q;

	logic [KEY_BITS-1:0] row_station;
	logic [CW-1:0]       row_count;
	logic [TB-1:0]       row_time;
	logic                hit;
	logic                older;

	assign rd_en   = act_q;
	assign rd_addr = issue_q[IW-1:0];

	// A row never written since reset reads as empty.
	always_comb begin
		row_station = valid_q[cmp_idx_s1] ? ram_station : '0;
		row_count   = valid_q[cmp_idx_s1] ? ram_count : '0;
		row_time    = valid_q[cmp_idx_s1] ? ram_time : '0;
		hit         = cmp_vld_s1 && !found_q && (row_station == key);
		older       = (cmp_idx_s1 == '0) || (row_time < old_time_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= 1'b0;
			issue_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			valid_q    <= '0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			done_q     <= cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);
			if (start) begin
				act_q   <= 1'b1;
				issue_q <= '0;
				found_q <= 1'b0;
			end else if (rd_en) begin
				issue_q <= issue_q + NW'(1);
				if (issue_q == LAST_ISSUE) begin
					act_q <= 1'b0;
				end
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (wr_mark) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
		if (hit) begin
			fnd_idx_q  <= cmp_idx_s1;
			fnd_cnt_q  <= row_count;
			fnd_time_q <= row_time;
		end
		if (cmp_vld_s1 && older) begin
			old_idx_q  <= cmp_idx_s1;
			old_time_q <= row_time;
		end
	end

	// A claimed row starts out cleared.
	always_comb begin
		stat.done  = done_q;
		stat.found = found_q;
		sel_idx    = found_q ? fnd_idx_q : old_idx_q;
		sel_count  = found_q ? fnd_cnt_q : '0;
		sel_time   = found_q ? fnd_time_q : '0;
	end

endmodule

// ===== rtl/windowed_distinct_contact_tracker.sv =====
// Windowed distinct-contact tracker, top level: sequencer, config and result register.
// The row scan (one row RAM read a cycle) and, for a note with a stored history, the
// addressee check (one a cycle) do the work; a zero station key, or a note with a zero
// addressee key, skips both. One request is in work at a time. Reset clears the
// sequencer, valid bits and result register at once; the addressee RAM is not cleared
// and needs no clearing pass. Depends on wdct_pkg, wdct_if, wdct_ram, wdct_row_scan.
module windowed_distinct_contact_tracker #(
	parameter int ROWS          = 6,
	parameter int ADDRS_PER_ROW = 3,
	parameter int KEY_BITS      = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wdct_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [wdct_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	wdct_req_if.sink                             req,
	wdct_rsp_if.source                           rsp
);

	localparam int TB    = wdct_pkg::TIME_BITS;
	localparam int IW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = $clog2(ADDRS_PER_ROW + 1);
	localparam int ADEP  = ROWS * ADDRS_PER_ROW;
	localparam int AAW   = (ADEP > 1) ? $clog2(ADEP) : 1;
	localparam int CMPW  = (CW > wdct_pkg::QMIN_BITS) ? CW : wdct_pkg::QMIN_BITS;
	localparam int RWW   = KEY_BITS + CW + TB;
	localparam logic [CW-1:0] CNT_MAX = CW'(ADDRS_PER_ROW);

	wdct_pkg::state_t state_q, state_d;

	logic [wdct_pkg::WIN_BITS-1:0]  window_q;
	logic [wdct_pkg::QMIN_BITS-1:0] qmin_q;

	logic                mode_q;
	logic [KEY_BITS-1:0] st_q;
	logic [KEY_BITS-1:0] ad_q;
	logic [TB-1:0]       now_q;

	logic [IW-1:0]  row_idx_q;
	logic [CW-1:0]  cnt_q;
	logic [AAW-1:0] base_q;
	logic           dup_q;
	logic [CW-1:0]  chk_issue_q;
	logic           chk_vld_s1;
	logic           chk_last_s1;
	logic           res_isq_q;
	logic           res_bec_q;
	logic           out_valid_q;
	logic           out_isq_q;
	logic           out_bec_q;

	logic                 accept;
	logic                 noop;
	logic                 ready_c;
	logic                 scan_start;
	logic                 row_we;
	logic                 chk_rd_en;
	logic                 out_load;
	logic                 append;
	logic [CW-1:0]        new_cnt;
	logic                 sel_stale;
	logic [CW-1:0]        eff_cnt;
	logic                 q_hit;
	logic                 dup_hit;

	logic                   scan_rd_en;
	logic [IW-1:0]          scan_rd_addr;
	wdct_pkg::scan_stat_t   scan_stat;
	logic [IW-1:0]          sel_idx;
	logic [CW-1:0]          sel_count;
	logic [TB-1:0]          sel_time;
	logic [RWW-1:0]         row_rdata;
	logic [KEY_BITS-1:0]    adr_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wdct_pkg::WINDOW_RESET;
			qmin_q   <= wdct_pkg::QMIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wdct_pkg::REG_WINDOW: window_q <= cfg_data[wdct_pkg::WIN_BITS-1:0];
				wdct_pkg::REG_QMIN:   qmin_q   <= cfg_data[wdct_pkg::QMIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign accept = req.valid && ready_c;
	assign noop   = (req.station_key == '0) ||
	                ((req.mode == wdct_pkg::MODE_NOTE) && (req.addressee_key == '0));

	// A stale history is forgotten only when the stored time is nonzero, but a
	// query treats every stored time as real.
	always_comb begin
		sel_stale = wdct_pkg::too_old(now_q, sel_time, window_q);
		eff_cnt   = ((sel_time != '0) && sel_stale) ? '0 : sel_count;
		q_hit     = scan_stat.found && !sel_stale &&
		            (CMPW'(sel_count) >= CMPW'(qmin_q));
		append    = !dup_q && (cnt_q < CNT_MAX);
		new_cnt   = cnt_q + CW'(append);
		dup_hit   = chk_vld_s1 && (adr_rdata == ad_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wdct_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = noop ? wdct_pkg::ST_FIN : wdct_pkg::ST_SCAN;
				end
			end
			wdct_pkg::ST_SCAN: begin
				if (scan_stat.done) begin
					if (mode_q == wdct_pkg::MODE_QUERY) begin
						state_d = wdct_pkg::ST_FIN;
					end else if (eff_cnt == '0) begin
						state_d = wdct_pkg::ST_WRITE;
					end else begin
						state_d = wdct_pkg::ST_CHECK;
					end
				end
			end
			wdct_pkg::ST_CHECK: begin
				if (chk_vld_s1 && chk_last_s1) begin
					state_d = wdct_pkg::ST_WRITE;
				end
			end
			wdct_pkg::ST_WRITE: state_d = wdct_pkg::ST_FIN;
			wdct_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = wdct_pkg::ST_IDLE;
				end
			end
			default: state_d = wdct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ready_c    = (state_q == wdct_pkg::ST_IDLE);
		scan_start = (state_q == wdct_pkg::ST_IDLE) && accept && !noop;
		chk_rd_en  = (state_q == wdct_pkg::ST_CHECK) && (chk_issue_q < cnt_q);
		row_we     = (state_q == wdct_pkg::ST_WRITE);
		out_load   = (state_q == wdct_pkg::ST_FIN) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wdct_pkg::ST_IDLE;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= chk_rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_last_s1 <= (chk_issue_q == (cnt_q - CW'(1)));
		if (accept) begin
			mode_q    <= req.mode;
			st_q      <= req.station_key;
			ad_q      <= req.addressee_key;
			now_q     <= req.now_seconds;
			res_isq_q <= 1'b0;
			res_bec_q <= 1'b0;
		end
		if ((state_q == wdct_pkg::ST_SCAN) && scan_stat.done) begin
			row_idx_q   <= sel_idx;
			cnt_q       <= eff_cnt;
			base_q      <= AAW'(sel_idx) * AAW'(ADDRS_PER_ROW);
			dup_q       <= 1'b0;
			chk_issue_q <= '0;
			res_isq_q   <= q_hit;
		end
		if (chk_rd_en) begin
			chk_issue_q <= chk_issue_q + CW'(1);
		end
		if (dup_hit) begin
			dup_q <= 1'b1;
		end
		if (row_we) begin
			res_isq_q <= (CMPW'(new_cnt) >= CMPW'(qmin_q));
			res_bec_q <= append && (CMPW'(new_cnt) == CMPW'(qmin_q));
		end
		if (out_load) begin
			out_isq_q <= res_isq_q;
			out_bec_q <= res_bec_q;
		end
	end

	assign req.ready        = ready_c;
	assign rsp.valid        = out_valid_q;
	assign rsp.is_queue     = out_isq_q;
	assign rsp.became_queue = out_bec_q;

	// Row RAM word: station key, addressee count, last-seen time.
	wdct_ram #(
		.WIDTH(RWW),
		.DEPTH(ROWS)
	) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_idx_q),
		.wdata({st_q, new_cnt, now_q}),
		.re   (scan_rd_en),
		.raddr(scan_rd_addr),
		.rdata(row_rdata)
	);

	wdct_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(ADEP)
	) u_adr_ram (
		.clk  (clk),
		.we   (row_we && append),
		.waddr(base_q + AAW'(cnt_q)),
		.wdata(ad_q),
		.re   (chk_rd_en),
		.raddr(base_q + AAW'(chk_issue_q)),
		.rdata(adr_rdata)
	);

	wdct_row_scan #(
		.ROWS    (ROWS),
		.KEY_BITS(KEY_BITS),
		.CW      (CW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.key        (st_q),
		.wr_mark    (row_we),
		.wr_idx     (row_idx_q),
		.ram_station(row_rdata[RWW-1:CW+TB]),
		.ram_count  (row_rdata[CW+TB-1:TB]),
		.ram_time   (row_rdata[TB-1:0]),
		.rd_en      (scan_rd_en),
		.rd_addr    (scan_rd_addr),
		.stat       (scan_stat),
		.sel_idx    (sel_idx),
		.sel_count  (sel_count),
		.sel_time   (sel_time)
	);

endmodule

// ===== rtl/wdct_checker.sv =====
// Port-level assertions for the tracker, bound to the top level.
// Depends only on the top level's ports.
module wdct_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic is_queue,
	input logic became_queue
);

	// A pending result is not withdrawn.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	// Reaching the minimum means the station counts as a queue.
	a_became_implies_queue: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!became_queue || is_queue))
		else $error("became_queue set without is_queue");

	// Only one request is worked on at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// Reset leaves no result pending.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result pending during reset");

endmodule

bind windowed_distinct_contact_tracker wdct_checker u_wdct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.is_queue    (rsp.is_queue),
	.became_queue(rsp.became_queue)
);

// ===== bench/windowed_distinct_contact_tracker_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the windowed distinct-contact tracker: directed and random requests,
// bursty sender, stalling receiver, results compared with a behavioural table of stations.
// Depends on wdct_pkg, the wdct_req_if and wdct_rsp_if interfaces and the tracker RTL.
module windowed_distinct_contact_tracker_test;

	localparam int ROW_COUNT  = 6;
	localparam int ADDR_SLOTS = 3;
	localparam int KEY_W      = 48;
	localparam int DRAIN_WAIT = ROW_COUNT + ADDR_SLOTS + 10;

	localparam int TIME_BITS     = wdct_pkg::TIME_BITS;
	localparam int WIN_BITS      = wdct_pkg::WIN_BITS;
	localparam int QMIN_BITS     = wdct_pkg::QMIN_BITS;
	localparam int CFG_IDX_BITS  = wdct_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS = wdct_pkg::CFG_DATA_BITS;

	typedef struct packed {
		logic               mode;
		logic [KEY_W-1:0]   station;
		logic [KEY_W-1:0]   addressee;
		logic [TIME_BITS-1:0] now;
	} contact_t;

	typedef struct packed {
		logic is_queue;
		logic became_queue;
	} queue_flags_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_PATTERN
	} rx_style_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	wdct_req_if #(.KEY_BITS(KEY_W)) req_ch ();
	wdct_rsp_if rsp_ch ();

	windowed_distinct_contact_tracker #(
		.ROWS(ROW_COUNT),
		.ADDRS_PER_ROW(ADDR_SLOTS),
		.KEY_BITS(KEY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Behavioural copy of the station table and its settings.
	logic [KEY_W-1:0]     tbl_station [ROW_COUNT];
	logic [KEY_W-1:0]     tbl_addr    [ROW_COUNT][ADDR_SLOTS];
	int                   tbl_count   [ROW_COUNT];
	logic [TIME_BITS-1:0] tbl_time    [ROW_COUNT];
	logic [WIN_BITS-1:0]  cur_win;
	int                   cur_qmin;

	queue_flags_t pending_flags[$];
	int           mismatches;

	// Sender and receiver pacing.
	int           burst_left;
	bit           sender_eager;
	rx_style_t    rx_style;
	int           rx_left;
	logic [15:0]  rx_pattern;

	logic [KEY_W-1:0]     station_pool [8];
	logic [KEY_W-1:0]     addr_pool    [5];
	logic [TIME_BITS-1:0] now_clock;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("windowed_distinct_contact_tracker: mismatch");
		$finish;
	end

	function automatic logic [KEY_W-1:0] random_key();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// A time that went backwards gives no age at all, hence the widened compare.
	function automatic logic aged_out(input logic [TIME_BITS-1:0] now,
	                                  input logic [TIME_BITS-1:0] last);
		return {1'b0, now} > ({1'b0, last} + (TIME_BITS+1)'(cur_win));
	endfunction

	function automatic int find_station(input logic [KEY_W-1:0] key);
		int i;
		for (i = 0; i < ROW_COUNT; i++)
			if (tbl_station[i] == key)
				return i;
		return -1;
	endfunction

	function automatic queue_flags_t track_contact(input contact_t c);
		queue_flags_t f;
		int r;
		int i;
		logic dup;
		f = '0;
		dup = 1'b0;
		if (c.mode == wdct_pkg::MODE_QUERY) begin
			if (c.station != '0) begin
				r = find_station(c.station);
				if (r >= 0 && !aged_out(c.now, tbl_time[r]) && tbl_count[r] >= cur_qmin)
					f.is_queue = 1'b1;
			end
		end else if (c.station != '0 && c.addressee != '0) begin
			r = find_station(c.station);
			if (r < 0) begin
				// Claim the least recently seen row; the lowest index wins a tie.
				r = 0;
				for (i = 1; i < ROW_COUNT; i++)
					if (tbl_time[i] < tbl_time[r])
						r = i;
				tbl_station[r] = c.station;
				tbl_count[r] = 0;
				tbl_time[r] = '0;
			end
			// A stored time of zero never makes a history stale.
			if (tbl_time[r] != '0 && aged_out(c.now, tbl_time[r]))
				tbl_count[r] = 0;
			tbl_time[r] = c.now;
			for (i = 0; i < tbl_count[r]; i++)
				if (tbl_addr[r][i] == c.addressee)
					dup = 1'b1;
			if (!dup && tbl_count[r] < ADDR_SLOTS) begin
				tbl_addr[r][tbl_count[r]] = c.addressee;
				tbl_count[r]++;
				if (tbl_count[r] == cur_qmin)
					f.became_queue = 1'b1;
			end
			f.is_queue = (tbl_count[r] >= cur_qmin);
		end
		return f;
	endfunction

	// Receiver: ready follows a style (steady, coin toss or rotating pattern) that is picked anew at random.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			rx_left = $urandom_range(20, 80);
			rx_pattern = 16'($urandom) | 16'h0001;
		end
		rx_left--;
		case (rx_style)
			RX_STEADY: begin
				rsp_ch.ready <= 1'b1;
			end
			RX_COIN: begin
				rsp_ch.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				rsp_ch.ready <= rx_pattern[0];
				rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		queue_flags_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_flags.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, is_queue %0b became_queue %0b",
				         $time, rsp_ch.is_queue, rsp_ch.became_queue);
			end else begin
				want = pending_flags.pop_front();
				if (rsp_ch.is_queue !== want.is_queue) begin
					mismatches++;
					$display("%0t: is_queue expected %0b got %0b",
					         $time, want.is_queue, rsp_ch.is_queue);
				end
				if (rsp_ch.became_queue !== want.became_queue) begin
					mismatches++;
					$display("%0t: became_queue expected %0b got %0b",
					         $time, want.became_queue, rsp_ch.became_queue);
				end
			end
		end
	end

	task automatic send_contact(input logic mode, input logic [KEY_W-1:0] station,
	                            input logic [KEY_W-1:0] addressee,
	                            input logic [TIME_BITS-1:0] now);
		contact_t c;
		int gap;
		c = '{mode: mode, station: station, addressee: addressee, now: now};
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_eager ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.mode <= c.mode;
		req_ch.station_key <= c.station;
		req_ch.addressee_key <= c.addressee;
		req_ch.now_seconds <= c.now;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_flags.push_back(track_contact(c));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_flags.size() != 0)
			@(posedge clk);
	endtask

	// Both registers are written back to back while the block is idle.
	task automatic set_config(input logic [WIN_BITS-1:0] win, input logic [QMIN_BITS-1:0] qmin);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= wdct_pkg::REG_WINDOW;
		cfg_data <= CFG_DATA_BITS'(win);
		@(posedge clk);
		cur_win = win;
		@(negedge clk);
		cfg_idx <= wdct_pkg::REG_QMIN;
		cfg_data <= CFG_DATA_BITS'(qmin);
		@(posedge clk);
		cur_qmin = qmin;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	localparam logic [KEY_W-1:0] KEY_X = '1;
	localparam logic [KEY_W-1:0] KEY_A = 48'h0000_0000_0001;
	localparam logic [KEY_W-1:0] KEY_B = '1;
	localparam logic [KEY_W-1:0] KEY_C = 48'hA5A5_5A5A_C3C3;
	localparam logic [KEY_W-1:0] KEY_D = 48'h5A5A_A5A5_3C3C;

	task automatic test_empty_and_zero_keys();
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, '0, '0);
		send_contact(wdct_pkg::MODE_QUERY, '0, '0, '0);
		send_contact(wdct_pkg::MODE_NOTE, '0, KEY_A, '0);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, '0, '0);
	endtask

	// Stored time of zero, duplicate addressee and a full row.
	task automatic test_addressee_list();
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_A, 32'd0);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_B, 32'd1000);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_B, 32'd1000);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_C, 32'd1000);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_D, 32'd1000);
	endtask

	// Window edge, a clock that runs backwards and the top of the time range.
	task automatic test_window_ageing();
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, '0, 32'd1240);
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, '0, 32'd1241);
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, KEY_A, 32'd500);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_A, '1);
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, '0, '1);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_B, '1);
	endtask

	task automatic test_row_eviction();
		int i;
		for (i = 1; i <= ROW_COUNT; i++)
			send_contact(wdct_pkg::MODE_NOTE, KEY_W'(i), KEY_C, TIME_BITS'(10 * i));
		send_contact(wdct_pkg::MODE_QUERY, KEY_W'(1), '0, 32'd70);
	endtask

	task automatic test_queue_min_zero();
		set_config(wdct_pkg::WINDOW_RESET, 2'd0);
		send_contact(wdct_pkg::MODE_QUERY, KEY_X, '0, '1);
		send_contact(wdct_pkg::MODE_NOTE, KEY_X, KEY_C, '1);
		send_contact(wdct_pkg::MODE_QUERY, KEY_D, '0, '1);
		send_contact(wdct_pkg::MODE_QUERY, KEY_W'(2), '0, 32'd25);
	endtask

	function automatic logic [TIME_BITS-1:0] advance_clock();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			now_clock = now_clock + TIME_BITS'($urandom_range(0, 3));
		else if (pick < 85)
			now_clock = now_clock + TIME_BITS'($urandom_range(0, cur_win));
		else if (pick < 95)
			now_clock = now_clock + TIME_BITS'(cur_win) + TIME_BITS'($urandom_range(1, 300));
		else
			now_clock = now_clock - TIME_BITS'($urandom_range(1, 100));
		return now_clock;
	endfunction

	// Mostly notes and queries on a small set of stations, so rows fill, age and
	// get reclaimed; the rest is fresh keys and zero keys.
	task automatic test_random_traffic(input int items);
		int n;
		int pick;
		logic [KEY_W-1:0] st;
		logic [KEY_W-1:0] ad;
		for (n = 0; n < 8; n++)
			station_pool[n] = random_key();
		for (n = 0; n < 5; n++)
			addr_pool[n] = random_key();
		now_clock = $urandom;
		sender_eager = ($urandom_range(0, 3) == 0);
		for (n = 0; n < items; n++) begin
			pick = $urandom_range(0, 99);
			st = station_pool[$urandom_range(0, 7)];
			ad = addr_pool[$urandom_range(0, 4)];
			if (pick < 45)
				send_contact(wdct_pkg::MODE_NOTE, st, ad, advance_clock());
			else if (pick < 80)
				send_contact(wdct_pkg::MODE_QUERY, st, random_key(), advance_clock());
			else if (pick < 88)
				send_contact(wdct_pkg::MODE_NOTE, random_key(), ad, advance_clock());
			else if (pick < 90)
				send_contact(wdct_pkg::MODE_NOTE, '0, ad, advance_clock());
			else if (pick < 92)
				send_contact(wdct_pkg::MODE_NOTE, st, '0, advance_clock());
			else if (pick < 95)
				send_contact(wdct_pkg::MODE_QUERY, '0, ad, advance_clock());
			else
				send_contact(wdct_pkg::MODE_QUERY, random_key(), ad, advance_clock());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = wdct_pkg::MODE_NOTE;
		req_ch.station_key = '0;
		req_ch.addressee_key = '0;
		req_ch.now_seconds = '0;
		rsp_ch.ready = 1'b0;
		rx_left = 0;
		rx_style = RX_STEADY;
		rx_pattern = 16'h0001;
		burst_left = 0;
		sender_eager = 1'b0;
		mismatches = 0;
		now_clock = '0;
		cur_win = wdct_pkg::WINDOW_RESET;
		cur_qmin = wdct_pkg::QMIN_RESET;
		for (int i = 0; i < ROW_COUNT; i++) begin
			tbl_station[i] = '0;
			tbl_count[i] = 0;
			tbl_time[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_zero_keys();
		test_addressee_list();
		test_window_ageing();
		test_row_eviction();
		test_queue_min_zero();

		set_config(wdct_pkg::WINDOW_RESET, wdct_pkg::QMIN_RESET);
		test_random_traffic(210);
		set_config(16'd1, 2'd1);
		test_random_traffic(210);
		set_config(16'hFFFF, 2'd3);
		test_random_traffic(210);
		set_config(WIN_BITS'($urandom_range(1, 65535)), QMIN_BITS'($urandom_range(1, 3)));
		test_random_traffic(210);
		set_config(WIN_BITS'($urandom_range(1, 65535)), 2'd0);
		test_random_traffic(234);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_flags.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $time, pending_flags.size());
		end
		if (mismatches == 0)
			$display("windowed_distinct_contact_tracker: match");
		else
			$display("windowed_distinct_contact_tracker: mismatch");
		$finish;
	end

endmodule
